// ===== sv/slid_pkg.sv =====
package slid_pkg;

	// default table depth
	localparam int CAPACITY_DEF = 16;
	// command queue depth between front and back
	localparam int Q_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/slid_fifo.sv =====
module slid_fifo import slid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    wr_cmd,
	input  logic    pop,
	output cmd_t    rd_cmd,
	output q_stat_t stat
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t          mem_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== sv/slid_front.sv =====
module slid_front import slid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	input  q_stat_t            qs,
	output logic               push,
	output cmd_t               wr_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	op_t  op_c;
	logic take;

	// decode the request code
	assign op_c = op_t'(mode);

	assign req_stall = valid_s1 && qs.full;
	assign take      = req_valid && !req_stall;
	assign push      = valid_s1 && !qs.full;
	assign wr_cmd    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op    <= op_c;
			cmd_s1.value <= value;
		end
	end

endmodule

// ===== sv/slid_back.sv =====
module slid_back import slid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_stat_t            qs,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         status,
	output logic signed [31:0] entry,
	output logic               entry_valid,
	output logic               last,
	output logic [CW-1:0]      count
);

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC, S_DUMP} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	cmd_t               cmd_q;
	logic signed [31:0] e_q [CAPACITY];
	logic signed [31:0] e_d [CAPACITY];
	logic signed [31:0] prv_e [CAPACITY];
	logic signed [31:0] nxt_e [CAPACITY];
	logic [CAPACITY-1:0] lt_c, eq_c, lt_q, eq_q, ins_at, ge_mask;
	logic               res_valid_q;
	logic [1:0]         status_q;
	logic signed [31:0] entry_q;
	logic               entry_valid_q;
	logic               last_q;
	logic               out_free, full, empty, hit, dump_last;
	logic               do_ins, do_del, do_rot;
	logic               res_set;

	assign out_free  = !res_valid_q || !res_stall;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign hit       = |eq_q;
	assign dump_last = (idx_q == count_q - CW'(1));
	assign q_pop     = (state_q == S_IDLE) && !qs.empty;

	// lanes at and above the first match
	assign ge_mask = ~((eq_q ^ (eq_q - CAPACITY'(1))) >> 1);

	assign do_ins = (state_q == S_EXEC) && out_free && (cmd_q.op == OP_INSERT) && !full;
	assign do_del = (state_q == S_EXEC) && out_free && (cmd_q.op == OP_DELETE)
		&& !empty && hit;
	assign do_rot = (state_q == S_DUMP) && out_free;

	// a new result is loaded this cycle
	assign res_set = ((state_q == S_EXEC) && out_free && !((cmd_q.op == OP_DUMP) && !empty))
		|| do_rot;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_lo
			assign ins_at[i] = 1'b1;
			assign prv_e[i]  = e_q[i];
		end else begin : g_mid
			assign ins_at[i] = lt_q[i-1];
			assign prv_e[i]  = e_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign nxt_e[i] = e_q[i];
		end else begin : g_below
			assign nxt_e[i] = e_q[i+1];
		end

		assign lt_c[i] = (count_q > CW'(i)) && (e_q[i] < cmd_q.value);
		assign eq_c[i] = (count_q > CW'(i)) && (e_q[i] == cmd_q.value);

		always_comb begin
			e_d[i] = e_q[i];
			if (do_ins && !lt_q[i]) begin
				e_d[i] = ins_at[i] ? cmd_q.value : prv_e[i];
			end else if (do_del && ge_mask[i]) begin
				e_d[i] = nxt_e[i];
			end else if (do_rot) begin
				// rotate the live part of the table by one
				if (count_q > CW'(i + 1)) begin
					e_d[i] = nxt_e[i];
				end else if (count_q == CW'(i + 1)) begin
					e_d[i] = e_q[0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			e_q[i] <= e_d[i];
		end
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == S_CMP) begin
			lt_q <= lt_c;
			eq_q <= eq_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			res_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			entry_q       <= '0;
			entry_valid_q <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			res_valid_q <= res_set || (res_valid_q && res_stall);
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						entry_q       <= '0;
						entry_valid_q <= 1'b0;
						last_q        <= 1'b1;
						state_q       <= ((cmd_q.op == OP_DUMP) && !empty) ? S_DUMP : S_IDLE;
						case (cmd_q.op)
							OP_INSERT: begin
								status_q <= full ? ST_FULL : ST_OK;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_DELETE: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else if (!hit) begin
									status_q <= ST_ABSENT;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q - CW'(1);
								end
							end
							OP_DUMP: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									idx_q <= '0;
								end
							end
							default: begin
								status_q <= empty ? ST_EMPTY : ST_OK;
								count_q  <= '0;
							end
						endcase
					end
				end
				S_DUMP: begin
					if (out_free) begin
						status_q      <= ST_OK;
						entry_q       <= e_q[0];
						entry_valid_q <= 1'b1;
						last_q        <= dump_last;
						idx_q         <= idx_q + CW'(1);
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign entry       = entry_q;
	assign entry_valid = entry_valid_q;
	assign last        = last_q;
	assign count       = count_q;

endmodule

// ===== sv/sorted_list_insert_delete_core.sv =====
// Sorted table of signed 32-bit values with insert, delete, in-order dump and clear.
// A request passes the front register and the command queue; the back end takes one
// request at a time in three steps (pop, compare, execute), holding in execute while
// its result stalls; a dump adds one result per entry via the single result register.
// Reset: arst_n asynchronously empties the table count, the queue and all handshakes;
// table cells are not cleared and are never read before being written.
module sorted_list_insert_delete_core import slid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         status,
	output logic signed [31:0] entry,
	output logic               entry_valid,
	output logic               last
);

	localparam int CW = $clog2(CAPACITY + 1);

	// front -> queue
	logic    push;
	cmd_t    wr_cmd;
	// queue -> back
	logic    pop;
	cmd_t    rd_cmd;
	q_stat_t qs;
	// live entry count, for checking only
	logic [CW-1:0] count;

	// Front end: registers a request and decodes its operation. It stalls the
	// requester only while its register is full and the queue cannot take it.
	slid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.mode      (mode),
		.value     (value),
		.qs        (qs),
		.push      (push),
		.wr_cmd    (wr_cmd)
	);

	// Short command queue decoupling front and back.
	slid_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (qs)
	);

	// Back end: row of table cells. Compare against every live cell at once and register
	// the result, then shift the row in the execute state. Insert opens a slot at the
	// first cell not below the value; delete closes the first equal cell. Dump rotates
	// the live cells through cell 0 once, so the table ends where it started.
	slid_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qs          (qs),
		.q_cmd       (rd_cmd),
		.q_pop       (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.entry       (entry),
		.entry_valid (entry_valid),
		.last        (last),
		.count       (count)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && entry_valid |-> status == ST_OK)
		else $error("dumped entry without ok status");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !entry_valid |-> entry == '0 && last)
		else $error("non-dump result not single or entry nonzero");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count != $past(count) |-> count == '0 || count == $past(count) + CW'(1)
			|| count == $past(count) - CW'(1))
		else $error("entry count jumped");
`endif

endmodule
